@@ hw/rtl/ppab_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppab_pkg: shared types and codes of the point plotter
// Pixel layout, request codes, status codes and register indexes.
// ----------------------------------------------------------------------------
package ppab_pkg;

    // One stored pixel, red in the top byte.
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    localparam int PIXEL_W = 24;

    // Request codes carried on s_tuser. Both codes with the high bit set clear.
    localparam logic [1:0] REQ_DRAW      = 2'd0;
    localparam logic [1:0] REQ_READ      = 2'd1;
    localparam logic [1:0] REQ_CLEAR     = 2'd2;
    localparam logic [1:0] REQ_CLEAR_ALT = 2'd3;

    // Status codes carried on m_tuser.
    localparam logic [1:0] ST_DRAWN   = 2'd0;
    localparam logic [1:0] ST_CLIPPED = 2'd1;
    localparam logic [1:0] ST_READ    = 2'd2;
    localparam logic [1:0] ST_CLEARED = 2'd3;

    // Configuration register indexes.
    localparam logic REG_CANVAS_WIDTH  = 1'b0;
    localparam logic REG_CANVAS_HEIGHT = 1'b1;

    localparam int CFG_W = 9;
    localparam logic [CFG_W-1:0] CANVAS_RESET = 9'd256;

endpackage

@@ hw/rtl/ppab_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppab_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered and holds
// its value in cycles without a read.
// ----------------------------------------------------------------------------
module ppab_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  logic                                     aclk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/ppab_blend.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppab_blend: per-channel alpha blend
// Registers the weighted source and destination products, then adds the
// rounding term and divides by 255 with a shift-and-add correction.
// ----------------------------------------------------------------------------
module ppab_blend (
    input  logic                aclk,
    input  logic                load,
    input  ppab_pkg::rgb_t      src,
    input  ppab_pkg::rgb_t      dst,
    input  logic [7:0]          alpha,
    output ppab_pkg::rgb_t      mixed
);

    import ppab_pkg::*;

    logic [2:0][15:0] s_prod_reg, s_prod_next;
    logic [2:0][15:0] d_prod_reg, d_prod_next;
    logic [2:0][7:0]  src_ch, dst_ch, mix_ch;
    logic [7:0]       inv_alpha;

    // Exact n / 255 for every n below 65280.
    function automatic logic [7:0] div255(input logic [15:0] n);
        logic [16:0] s;
        s = {1'b0, n} + 17'(n[15:8]) + 17'd1;
        return s[15:8];
    endfunction

    assign src_ch    = src;
    assign dst_ch    = dst;
    assign inv_alpha = 8'd255 - alpha;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            s_prod_next[i] = 16'(inv_alpha) * 16'(src_ch[i]);
            d_prod_next[i] = 16'(alpha) * 16'(dst_ch[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            s_prod_reg <= s_prod_next;
            d_prod_reg <= d_prod_next;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            mix_ch[i] = div255(s_prod_reg[i] + d_prod_reg[i] + 16'd127);
        end
    end

    assign mixed = mix_ch;

endmodule

@@ hw/rtl/point_plot_alpha_blend.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_plot_alpha_blend: framebuffer point plotter with alpha blending
// Maps normalized points to pixels, blends into an RGB frame store, reads
// pixels back and clears the store.
// ----------------------------------------------------------------------------
// Requests arrive on the s_ stream: s_tuser carries the request kind and
// s_tdata the point, source color, alpha and read address. Every request
// produces exactly one result transfer on the m_ stream, with the status on
// m_tuser and the pixel color on m_tdata. The user sets the canvas size through
// the plain write port only while the block is idle, which it does not enforce.
// The block works on one request at a time, stepping a sequencer around a
// single frame store RAM with registered reads. A drawn point passes through
// scale, address and read, product, divide and write back, and result before
// the next request is accepted; a read skips the scaling, and a clipped
// request goes from the address step straight to the result.
// A clear writes all MAX_WIDTH * MAX_HEIGHT words, one per cycle, and then
// reports from S_OUT once the output register is free.
// Reset starts the same clearing pass (MAX_WIDTH * MAX_HEIGHT words, 65536 by
// default) with s_tready low and no result; configuration writes are taken
// throughout. A stalled receiver only holds the finished result in the output
// register; the next request is still accepted and runs up to its own result.
// ----------------------------------------------------------------------------
module point_plot_alpha_blend #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Request stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    // point_x[15:0], point_y[31:16], src_red[39:32], src_green[47:40],
    // src_blue[55:48], src_alpha[63:56], read_col[71:64], read_row[79:72]
    input  logic [79:0] s_tdata,
    // req_type[1:0]
    input  logic [1:0]  s_tuser,
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    // out_red[7:0], out_green[15:8], out_blue[23:16]
    output logic [23:0] m_tdata,
    // status[1:0]
    output logic [1:0]  m_tuser,
    // Configuration write port.
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_index,
    input  logic [8:0]  cfg_wr_data
);

    import ppab_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Sequencer states, one-hot.
    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_MAP  = 7'b0000010,
        S_ADDR = 7'b0000100,
        S_MIX  = 7'b0001000,
        S_DIV  = 7'b0010000,
        S_OUT  = 7'b0100000,
        S_CLR  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // Canvas registers.
    logic [CFG_W-1:0] cw_reg, ch_reg;

    // Latched request fields.
    logic               is_draw_reg;
    logic signed [15:0] pt_x_reg, pt_y_reg;
    rgb_t               src_reg;
    logic [7:0]         alpha_reg;
    logic [7:0]         col_reg, row_reg;

    // Scaled coordinates, value = t / 32768.
    logic signed [26:0] tx_reg, ty_reg, tx_next, ty_next;
    logic signed [16:0] ox, oy;

    // Pixel address of the current request, kept for the write back.
    logic [AW-1:0] addr_reg, addr_next;

    // Clearing pass.
    logic [AW-1:0] clr_addr_reg, clr_addr_next;
    logic          clr_report_reg, clr_report_next;

    // Pending result and output register.
    logic [1:0] res_status_reg, res_status_next;
    rgb_t       res_word_reg, res_word_next;
    logic       m_valid_reg, m_valid_next;
    logic [1:0] m_status_reg;
    rgb_t       m_word_reg;

    // Address stage.
    logic signed [26:0] rx, ry;
    logic [11:0]        px, py;
    logic               draw_in, read_in;
    logic [11:0]        sel_col, sel_row;

    // RAM and blend hookup.
    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr;
    rgb_t          ram_wdata, ram_rdata;
    rgb_t          blend_out;
    logic          blend_load;
    logic          accept, out_load;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cw_reg <= CANVAS_RESET;
            ch_reg <= CANVAS_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                REG_CANVAS_WIDTH:  cw_reg <= cfg_wr_data;
                REG_CANVAS_HEIGHT: ch_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Scaling: (q + 16384) * size. The register value is used as written.
    assign ox      = {pt_x_reg[15], pt_x_reg} + 17'sd16384;
    assign oy      = {pt_y_reg[15], pt_y_reg} + 17'sd16384;
    assign tx_next = ox * $signed({1'b0, cw_reg});
    assign ty_next = oy * $signed({1'b0, ch_reg});

    // Rounding half away from zero. A scaled value at or below -0.5 rounds
    // to a negative pixel and clips, which is exactly the case where
    // t + 16384 is not positive; otherwise the pixel is that sum shifted down.
    assign rx = tx_reg + 27'sd16384;
    assign ry = ty_reg + 27'sd16384;
    assign px = rx[26:15];
    assign py = ry[26:15];

    // The effective canvas is the register limited to the store size.
    assign draw_in = (rx > 27'sd0) && (ry > 27'sd0)
                  && (px < {3'd0, cw_reg}) && (32'(px) < MAX_WIDTH)
                  && (py < {3'd0, ch_reg}) && (32'(py) < MAX_HEIGHT);
    assign read_in = ({1'b0, col_reg} < cw_reg) && (32'(col_reg) < MAX_WIDTH)
                  && ({1'b0, row_reg} < ch_reg) && (32'(row_reg) < MAX_HEIGHT);

    assign sel_col   = is_draw_reg ? px : {4'd0, col_reg};
    assign sel_row   = is_draw_reg ? py : {4'd0, row_reg};
    assign addr_next = AW'(sel_row) * AW'(MAX_WIDTH) + AW'(sel_col);

    // Sequencer.
    always_comb begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        clr_report_next = clr_report_reg;
        res_status_next = res_status_reg;
        res_word_next   = res_word_reg;
        ram_re          = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = addr_reg;
        ram_wdata       = blend_out;
        blend_load      = 1'b0;
        out_load        = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    unique case (s_tuser) inside
                        REQ_DRAW: state_next = S_MAP;
                        REQ_READ: state_next = S_ADDR;
                        REQ_CLEAR, REQ_CLEAR_ALT: begin
                            clr_addr_next   = '0;
                            clr_report_next = 1'b1;
                            state_next      = S_CLR;
                        end
                        default: ;
                    endcase
                end
            end
            S_MAP: begin
                state_next = S_ADDR;
            end
            S_ADDR: begin
                if (is_draw_reg ? draw_in : read_in) begin
                    ram_re     = 1'b1;
                    state_next = S_MIX;
                end else begin
                    res_status_next = ST_CLIPPED;
                    res_word_next   = '0;
                    state_next      = S_OUT;
                end
            end
            S_MIX: begin
                // The stored pixel is on the RAM output now.
                if (is_draw_reg) begin
                    blend_load = 1'b1;
                    state_next = S_DIV;
                end else begin
                    res_status_next = ST_READ;
                    res_word_next   = ram_rdata;
                    state_next      = S_OUT;
                end
            end
            S_DIV: begin
                ram_we          = 1'b1;
                res_status_next = ST_DRAWN;
                res_word_next   = blend_out;
                state_next      = S_OUT;
            end
            S_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_CLR: begin
                ram_we        = 1'b1;
                ram_waddr     = clr_addr_reg;
                ram_wdata     = '0;
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(DEPTH - 1)) begin
                    res_status_next = ST_CLEARED;
                    res_word_next   = '0;
                    // The pass after reset gives no result.
                    state_next      = clr_report_reg ? S_OUT : S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign m_valid_next = out_load ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_CLR;
            clr_addr_reg   <= '0;
            clr_report_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            clr_report_reg <= clr_report_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (accept) begin
            is_draw_reg <= (s_tuser == REQ_DRAW);
            pt_x_reg    <= s_tdata[15:0];
            pt_y_reg    <= s_tdata[31:16];
            src_reg     <= s_tdata[55:32];
            alpha_reg   <= s_tdata[63:56];
            col_reg     <= s_tdata[71:64];
            row_reg     <= s_tdata[79:72];
        end
        if (state_reg == S_MAP) begin
            tx_reg <= tx_next;
            ty_reg <= ty_next;
        end
        if (state_reg == S_ADDR) begin
            addr_reg <= addr_next;
        end
        res_status_reg <= res_status_next;
        res_word_reg   <= res_word_next;
        if (out_load) begin
            m_status_reg <= res_status_reg;
            m_word_reg   <= res_word_reg;
        end
    end

    // src_reg holds the bus layout, red lowest, while rgb_t has red in its top byte.
    ppab_blend u_blend (
        .aclk  (aclk),
        .load  (blend_load),
        .src   ({src_reg.blue, src_reg.green, src_reg.red}),
        .dst   (ram_rdata),
        .alpha (alpha_reg),
        .mixed (blend_out)
    );

    ppab_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (DEPTH)
    ) u_frame_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (addr_next),
        .rdata (ram_rdata)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {m_word_reg.blue, m_word_reg.green, m_word_reg.red};

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the point plotter with alpha blending
// Drives draw, read and clear requests over the request stream, predicts each
// status and color with a behavioral copy of the frame store, and checks every
// result transfer in order under several canvas sizes and idling patterns.
// ----------------------------------------------------------------------------
module tb_top;
    import ppab_pkg::*;

    localparam int MAX_W = 256;
    localparam int MAX_H = 256;
    // The slowest stretch without any transfer is a clear, or the clearing pass
    // after reset, which writes one stored word per cycle. Receiver stalls and
    // sender gaps are short next to a full pass, so four times a full pass is a
    // generous limit.
    localparam int WATCHDOG_LIMIT = 4 * MAX_W * MAX_H;
    localparam int PHASE_ITEMS = 110;
    // Every clear walks the whole store, so random clears are kept rare.
    localparam int MAX_RANDOM_CLEARS = 2;

    // One expected result transfer: status code plus the returned color.
    typedef struct packed {
        logic [1:0] status;
        rgb_t       color;
    } plot_result_t;

    // Every block input starts at a known value.
    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;
    logic [1:0]  s_tuser = REQ_DRAW;
    logic        m_tvalid;
    logic        m_tready = 1'b1;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_wr_index = REG_CANVAS_WIDTH;
    logic [8:0]  cfg_wr_data = '0;

    // Behavioral copy of the frame store and the canvas registers. The store
    // starts at zero because reset clears the block's store as well.
    rgb_t         pixel_mem [MAX_W*MAX_H];
    logic [8:0]   model_width = CANVAS_RESET;
    logic [8:0]   model_height = CANVAS_RESET;
    plot_result_t pending_results[$];
    int           last_col = 0;
    int           last_row = 0;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int error_count = 0;
    int idle_cycles = 0;
    int count_drawn = 0;
    int count_clipped = 0;
    int count_read = 0;
    int count_cleared = 0;
    int random_clears = 0;

    initial begin
        foreach (pixel_mem[i]) pixel_mem[i] = '0;
    end

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    point_plot_alpha_blend #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data)
    );

    // The receiver stalls at random with the current probability; at zero it
    // is always ready.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // The watchdog ends the run when no transfer has happened on either
    // stream for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[%0t] watchdog expired after %0d cycles without a transfer",
                     $time, idle_cycles);
            $display("point_plot_alpha_blend verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic report_mismatch(string msg);
        error_count++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // Maps a Q2.14 coordinate to a pixel index: round((v + 1) * size / 2) with
    // halves rounded away from zero. The sum is scaled by 32768 throughout.
    function automatic int pixel_coord(logic signed [15:0] v, logic [8:0] size);
        int t;
        t = (int'(v) + 16384) * int'(size);
        if (t >= 0) return (t + 16384) / 32768;
        return -((16384 - t) / 32768);
    endfunction

    // Alpha weights the stored color, not the source.
    function automatic logic [7:0] blend_channel(logic [7:0] src, logic [7:0] dst,
                                                 logic [7:0] alpha);
        int mixed;
        mixed = ((255 - int'(alpha)) * int'(src) + int'(alpha) * int'(dst) + 127) / 255;
        return mixed[7:0];
    endfunction

    // Applies one accepted request to the store copy and returns the result
    // that the block must send for it.
    function automatic plot_result_t plot_step(logic [1:0] kind, logic [79:0] data);
        plot_result_t res;
        int ew;
        int eh;
        int px;
        int py;
        int addr;
        rgb_t dst;
        logic [7:0] col;
        logic [7:0] row;
        res.status = ST_CLIPPED;
        res.color = '0;
        // Bounds are the registers limited to the store size; scaling below
        // still uses the registers as written.
        ew = (model_width > MAX_W) ? MAX_W : int'(model_width);
        eh = (model_height > MAX_H) ? MAX_H : int'(model_height);
        if (kind == REQ_CLEAR || kind == REQ_CLEAR_ALT) begin
            foreach (pixel_mem[i]) pixel_mem[i] = '0;
            res.status = ST_CLEARED;
        end else if (kind == REQ_DRAW) begin
            px = pixel_coord(data[15:0], model_width);
            py = pixel_coord(data[31:16], model_height);
            if (px >= 0 && py >= 0 && px < ew && py < eh) begin
                addr = py * MAX_W + px;
                dst = pixel_mem[addr];
                res.color.red   = blend_channel(data[39:32], dst.red, data[63:56]);
                res.color.green = blend_channel(data[47:40], dst.green, data[63:56]);
                res.color.blue  = blend_channel(data[55:48], dst.blue, data[63:56]);
                pixel_mem[addr] = res.color;
                res.status = ST_DRAWN;
                last_col = px;
                last_row = py;
            end
        end else begin
            col = data[71:64];
            row = data[79:72];
            if (col < ew && row < eh) begin
                res.color = pixel_mem[int'(row) * MAX_W + int'(col)];
                res.status = ST_READ;
            end
        end
        return res;
    endfunction

    // Sends one request and records its expected result once the transfer has
    // been accepted. It is always entered right after a rising edge, and
    // leaves s_tvalid high so that back-to-back requests need no gap.
    task automatic send_request(logic [1:0] kind, logic [15:0] x, logic [15:0] y,
                                rgb_t src, logic [7:0] alpha, logic [7:0] col,
                                logic [7:0] row);
        logic [79:0] packed_data;
        packed_data = {row, col, alpha, src.blue, src.green, src.red, y, x};
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= packed_data;
        s_tuser  <= kind;
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(plot_step(kind, packed_data));
    endtask

    // Unused fields of each request carry random values, so every bit of the
    // request toggles even in the directed part.
    task automatic draw_point(logic [15:0] x, logic [15:0] y, rgb_t src,
                              logic [7:0] alpha);
        send_request(REQ_DRAW, x, y, src, alpha, 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)));
    endtask

    task automatic read_pixel(logic [7:0] col, logic [7:0] row);
        send_request(REQ_READ, 16'($urandom_range(0, 65535)),
                     16'($urandom_range(0, 65535)),
                     rgb_t'($urandom), 8'($urandom_range(0, 255)), col, row);
    endtask

    task automatic clear_canvas(logic [1:0] kind);
        send_request(kind, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                     rgb_t'($urandom), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    endtask

    // Holds the sender off until every expected result has come back. It
    // always lets at least one edge pass, so s_tvalid is never assigned twice
    // in one time step.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    // Writes both canvas registers; only called while nothing is in flight.
    task automatic set_canvas(logic [8:0] width, logic [8:0] height);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= REG_CANVAS_WIDTH;
        cfg_wr_data  <= width;
        @(posedge aclk);
        model_width = width;
        cfg_wr_index <= REG_CANVAS_HEIGHT;
        cfg_wr_data  <= height;
        @(posedge aclk);
        model_height = height;
        cfg_wr_en <= 1'b0;
    endtask

    // Each result transfer is compared field by field with the oldest
    // expectation.
    always @(posedge aclk) begin : result_check
        plot_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result with nothing pending, status %0d data %06h",
                                          m_tuser, m_tdata));
            end else begin
                want = pending_results.pop_front();
                if (m_tuser !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d", m_tuser, want.status));
                if (m_tdata[7:0] !== want.color.red)
                    report_mismatch($sformatf("red %02h, expected %02h",
                                              m_tdata[7:0], want.color.red));
                if (m_tdata[15:8] !== want.color.green)
                    report_mismatch($sformatf("green %02h, expected %02h",
                                              m_tdata[15:8], want.color.green));
                if (m_tdata[23:16] !== want.color.blue)
                    report_mismatch($sformatf("blue %02h, expected %02h",
                                              m_tdata[23:16], want.color.blue));
                case (want.status)
                    ST_DRAWN:   count_drawn++;
                    ST_CLIPPED: count_clipped++;
                    ST_READ:    count_read++;
                    default:    count_cleared++;
                endcase
            end
        end
    end

    // Directed draws on the reset canvas of 256 by 256: blending at both alpha
    // extremes and in between, coordinate extremes, and the rounding edges.
    task automatic test_draw_extremes();
        // The origin lands on the center pixel; alpha zero takes the source.
        draw_point(16'd0, 16'd0, rgb_t'(24'hFF8001), 8'd0);
        // Full alpha keeps the stored color whatever the source.
        draw_point(16'd0, 16'd0, rgb_t'(24'h000000), 8'd255);
        // A mid alpha mixes the two.
        draw_point(16'd0, 16'd0, rgb_t'(24'h00FF00), 8'd128);
        // The most negative and most positive coordinates both fall outside.
        draw_point(16'h8000, 16'h8000, rgb_t'(24'hFFFFFF), 8'd0);
        draw_point(16'h7FFF, 16'd0, rgb_t'(24'hFFFFFF), 8'd0);
        // Minus one maps to the first pixel of each axis.
        draw_point(-16'sd16384, -16'sd16384, rgb_t'(24'hFFFFFF), 8'd0);
        // A slightly negative scaled value rounds to zero and is kept, while
        // the row lands on the last pixel.
        draw_point(-16'sd16400, 16'sd16300, rgb_t'(24'h123456), 8'd77);
        // Exactly half a pixel below zero rounds away from zero and clips.
        draw_point(-16'sd16448, 16'd0, rgb_t'(24'hABCDEF), 8'd0);
        read_pixel(8'd128, 8'd128);
        read_pixel(8'd0, 8'd255);
        // A pixel that was never drawn still reads as cleared.
        read_pixel(8'd255, 8'd255);
    endtask

    // Both clear codes zero the store.
    task automatic test_clear();
        clear_canvas(REQ_CLEAR);
        read_pixel(8'd128, 8'd128);
        draw_point(16'd0, 16'd0, rgb_t'(24'h5A5AA5), 8'd0);
        clear_canvas(REQ_CLEAR_ALT);
        read_pixel(8'd128, 8'd128);
    endtask

    // Canvas register settings: zero size, one pixel, and sizes beyond the
    // store. The store contents survive every change of size.
    task automatic test_canvas_config();
        draw_point(16'd0, 16'd0, rgb_t'(24'hC0FFEE), 8'd0);
        // The sender waits for every result before the registers change.
        wait_drained();
        set_canvas(9'd0, 9'd256);
        draw_point(16'd0, 16'd0, rgb_t'(24'hFFFFFF), 8'd0);
        read_pixel(8'd0, 8'd0);
        wait_drained();
        set_canvas(9'd1, 9'd1);
        // On a one-pixel canvas the origin rounds up to pixel 1 and clips.
        draw_point(16'd0, 16'd0, rgb_t'(24'hFFFFFF), 8'd0);
        draw_point(-16'sd16384, -16'sd16384, rgb_t'(24'h804020), 8'd0);
        read_pixel(8'd1, 8'd0);
        read_pixel(8'd0, 8'd0);
        wait_drained();
        // Scaling uses 511, but the bounds stop at the store size.
        set_canvas(9'd511, 9'd511);
        draw_point(16'd0, 16'd0, rgb_t'(24'hFFFFFF), 8'd0);
        read_pixel(8'd255, 8'd255);
        read_pixel(8'd128, 8'd128);
    endtask

    // Random point values for draws: mostly inside the unit square, the rest
    // anywhere in the 16-bit range.
    function automatic logic [15:0] random_coord();
        if ($urandom_range(0, 4) != 0) return 16'($urandom_range(0, 32767) - 16384);
        return 16'($urandom_range(0, 65535));
    endfunction

    function automatic logic [7:0] random_alpha();
        case ($urandom_range(0, 9))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // One phase of random requests under a given canvas and idling pattern.
    // Reads often go back to the last drawn pixel, so that blended values
    // are read out as well as produced.
    task automatic run_random_phase(int idle, int stall, logic [8:0] width,
                                    logic [8:0] height);
        int ew;
        int eh;
        int pick;
        logic [7:0] col;
        logic [7:0] row;
        wait_drained();
        set_canvas(width, height);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        ew = (width > MAX_W) ? MAX_W : int'(width);
        eh = (height > MAX_H) ? MAX_H : int'(height);
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(0, 39) == 0) wait_drained();
            if (random_clears < MAX_RANDOM_CLEARS && $urandom_range(0, 149) == 0) begin
                random_clears++;
                clear_canvas($urandom_range(0, 1) ? REQ_CLEAR : REQ_CLEAR_ALT);
            end
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                draw_point(random_coord(), random_coord(), rgb_t'($urandom), random_alpha());
            end else begin
                if (pick < 75) begin
                    col = 8'(last_col);
                    row = 8'(last_row);
                end else if (pick < 90 && ew > 0 && eh > 0) begin
                    col = 8'($urandom_range(0, ew - 1));
                    row = 8'($urandom_range(0, eh - 1));
                end else begin
                    col = 8'($urandom_range(0, 255));
                    row = 8'($urandom_range(0, 255));
                end
                read_pixel(col, row);
            end
        end
    endtask

    // Four idling patterns, each with its own canvas: no idling, a mostly
    // idle sender, a mostly stalled receiver, and light idling on both sides.
    task automatic test_random_traffic();
        run_random_phase(0, 0, 9'd256, 9'd256);
        run_random_phase(66, 0, 9'($urandom_range(1, 24)), 9'($urandom_range(1, 24)));
        run_random_phase(0, 66, 9'($urandom_range(257, 511)), 9'($urandom_range(1, 511)));
        run_random_phase(17, 17, 9'($urandom_range(1, 64)), 9'($urandom_range(1, 64)));
    endtask

    initial begin
        // Reset is held low at the start; afterwards the block runs its own
        // clearing pass with s_tready low, which send_request simply waits out.
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_draw_extremes();
        test_clear();
        test_canvas_config();
        test_random_traffic();

        // Let the last results arrive, then watch a little longer for any
        // transfer that should not be there.
        wait_drained();
        repeat (20) @(posedge aclk);
        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));

        $display("Covered %0d drawn points, %0d clipped requests, %0d pixel reads, %0d clears.",
                 count_drawn, count_clipped, count_read, count_cleared);
        $display("Canvas sizes ranged from zero to beyond the store under four idling patterns.");
        if (error_count == 0) begin
            $display("point_plot_alpha_blend verification clean");
        end else begin
            $display("point_plot_alpha_blend verification failed");
        end
        $finish;
    end

endmodule
